>>> sv/tccs_pkg.sv
// shared constants, control word layout and microcode program of the text console
package tccs_pkg;

  // geometry defaults
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // field widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int CELL_IDX_W = 11;
  localparam int CURSOR_W   = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 1;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // microcode address
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] step_t;

  localparam step_t ST_RSTFILL = 4'd0;
  localparam step_t ST_IDLE    = 4'd1;
  localparam step_t ST_WRAP    = 4'd2;
  localparam step_t ST_CHK1    = 4'd3;
  localparam step_t ST_NLTEST  = 4'd4;
  localparam step_t ST_WRCHAR  = 4'd5;
  localparam step_t ST_NL      = 4'd6;
  localparam step_t ST_CHK2    = 4'd7;
  localparam step_t ST_DONE    = 4'd8;
  localparam step_t ST_CLEAR   = 4'd9;
  localparam step_t ST_HOME    = 4'd10;
  localparam step_t ST_READ    = 4'd11;
  localparam step_t ST_SCOPY   = 4'd12;
  localparam step_t ST_SDRAIN  = 4'd13;
  localparam step_t ST_SBLANK  = 4'd14;
  localparam step_t ST_SRET    = 4'd15;

  // next-address kind
  typedef logic [1:0] nx_t;
  localparam nx_t NX_JUMP_IF  = 2'd0;  // cond ? target : step + 1
  localparam nx_t NX_STAY_IF  = 2'd1;  // cond ? step : target
  localparam nx_t NX_DISPATCH = 2'd2;  // wait for a beat, then branch on command
  localparam nx_t NX_RET      = 2'd3;  // back to the saved return step

  typedef logic [2:0] cond_t;
  localparam cond_t C_ALWAYS   = 3'd0;
  localparam cond_t C_ROWOVER  = 3'd1;
  localparam cond_t C_NEWLINE  = 3'd2;
  localparam cond_t C_LOOPMORE = 3'd3;
  localparam cond_t C_OUTBUSY  = 3'd4;

  typedef logic [2:0] cur_t;
  localparam cur_t CUR_HOLD    = 3'd0;
  localparam cur_t CUR_WRAP    = 3'd1;
  localparam cur_t CUR_CLAMP   = 3'd2;
  localparam cur_t CUR_NEWLINE = 3'd3;
  localparam cur_t CUR_ADV     = 3'd4;
  localparam cur_t CUR_HOME    = 3'd5;

  typedef logic [2:0] wr_t;
  localparam wr_t WR_NONE       = 3'd0;
  localparam wr_t WR_ZERO_PTR   = 3'd1;
  localparam wr_t WR_BLANK_PTR  = 3'd2;
  localparam wr_t WR_CHAR_CUR   = 3'd3;
  localparam wr_t WR_BLANK_LAST = 3'd4;

  typedef logic [1:0] rd_t;
  localparam rd_t RD_NONE  = 2'd0;
  localparam rd_t RD_CELL  = 2'd1;
  localparam rd_t RD_SHIFT = 2'd2;

  typedef logic [1:0] lim_t;
  localparam lim_t LIM_NONE  = 2'd0;
  localparam lim_t LIM_CELLS = 2'd1;
  localparam lim_t LIM_MOVE  = 2'd2;
  localparam lim_t LIM_COLS  = 2'd3;

  typedef struct packed {
    nx_t   nx;
    cond_t cond;
    logic  call;
    step_t target;
    cur_t  cur;
    wr_t   wr;
    rd_t   rd;
    lim_t  lim;
    logic  out_load;
  } ctrl_t;

  typedef struct packed {
    logic row_over;
    logic newline;
    logic loop_more;
  } dp_stat_t;

  function automatic ctrl_t mk(input nx_t nx, input cond_t cond, input logic call,
                               input step_t target, input cur_t cur, input wr_t wr,
                               input rd_t rd, input lim_t lim, input logic out_load);
    ctrl_t c;
    c.nx       = nx;
    c.cond     = cond;
    c.call     = call;
    c.target   = target;
    c.cur      = cur;
    c.wr       = wr;
    c.rd       = rd;
    c.lim      = lim;
    c.out_load = out_load;
    return c;
  endfunction

  // the program
  function automatic ctrl_t ucode(input step_t a);
    ctrl_t c;
    unique case (a)
      ST_RSTFILL: c = mk(NX_STAY_IF, C_LOOPMORE, 1'b0, ST_IDLE, CUR_HOLD, WR_ZERO_PTR,
                         RD_NONE, LIM_CELLS, 1'b0);
      ST_IDLE:    c = mk(NX_DISPATCH, C_ALWAYS, 1'b0, ST_IDLE, CUR_HOLD, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_WRAP:    c = mk(NX_JUMP_IF, C_ALWAYS, 1'b0, ST_CHK1, CUR_WRAP, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_CHK1:    c = mk(NX_JUMP_IF, C_ROWOVER, 1'b1, ST_SCOPY, CUR_CLAMP, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_NLTEST:  c = mk(NX_JUMP_IF, C_NEWLINE, 1'b0, ST_NL, CUR_HOLD, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_WRCHAR:  c = mk(NX_JUMP_IF, C_ALWAYS, 1'b0, ST_DONE, CUR_ADV, WR_CHAR_CUR,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_NL:      c = mk(NX_JUMP_IF, C_ALWAYS, 1'b0, ST_CHK2, CUR_NEWLINE, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_CHK2:    c = mk(NX_JUMP_IF, C_ROWOVER, 1'b1, ST_SCOPY, CUR_CLAMP, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_DONE:    c = mk(NX_STAY_IF, C_OUTBUSY, 1'b0, ST_IDLE, CUR_HOLD, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b1);
      ST_CLEAR:   c = mk(NX_STAY_IF, C_LOOPMORE, 1'b0, ST_HOME, CUR_HOLD, WR_BLANK_PTR,
                         RD_NONE, LIM_CELLS, 1'b0);
      ST_HOME:    c = mk(NX_JUMP_IF, C_ALWAYS, 1'b0, ST_DONE, CUR_HOME, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_READ:    c = mk(NX_JUMP_IF, C_ALWAYS, 1'b0, ST_DONE, CUR_HOLD, WR_NONE,
                         RD_CELL, LIM_NONE, 1'b0);
      ST_SCOPY:   c = mk(NX_STAY_IF, C_LOOPMORE, 1'b0, ST_SDRAIN, CUR_HOLD, WR_NONE,
                         RD_SHIFT, LIM_MOVE, 1'b0);
      ST_SDRAIN:  c = mk(NX_JUMP_IF, C_ALWAYS, 1'b0, ST_SBLANK, CUR_HOLD, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      ST_SBLANK:  c = mk(NX_STAY_IF, C_LOOPMORE, 1'b0, ST_SRET, CUR_HOLD, WR_BLANK_LAST,
                         RD_NONE, LIM_COLS, 1'b0);
      ST_SRET:    c = mk(NX_RET, C_ALWAYS, 1'b0, ST_IDLE, CUR_HOLD, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
      default:    c = mk(NX_JUMP_IF, C_ALWAYS, 1'b0, ST_IDLE, CUR_HOLD, WR_NONE,
                         RD_NONE, LIM_NONE, 1'b0);
    endcase
    return c;
  endfunction

  // entry step for each command; unused command goes straight to the result
  function automatic step_t dispatch(input logic [CMD_W-1:0] cmd);
    step_t s;
    unique case (cmd)
      CMD_PUT:   s = ST_WRAP;
      CMD_CLEAR: s = ST_CLEAR;
      CMD_READ:  s = ST_READ;
      default:   s = ST_DONE;
    endcase
    return s;
  endfunction

endpackage

>>> sv/text_console_cursor_scroll.sv
// top level of the text console: stream ports, attribute register, result register
//
// Text console holding a ROWS x COLUMNS store of 16-bit cells (attribute byte high,
// character byte low) and a cursor. Each input beat carries a command: put a
// character (newline moves to the next row, anything else is written with the
// current attribute and advances the column, a full line wraps on the next put,
// running off the bottom scrolls the screen up and blanks the last row), clear the
// screen to blanks and home the cursor, or read back one cell. Every beat gives
// exactly one result beat with the cursor index after the command, the echoed
// serial byte on a put, and the cell data on a read. Items are handled one at a
// time by a 16-step microcode program over a single-write-port cell store; a
// scroll inside a put copies or blanks one cell per cycle. After reset the store
// is cleared to zero in a pass during which no beat is accepted; attribute writes
// are taken at any time. The next input beat is accepted while a finished result
// still waits on the output.
module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
)(
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // command[1:0], char_code[9:2], cell_index[20:10]
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // cursor_index[10:0], serial_byte[18:11],
                                          // cell_data[34:19]
  output logic [M_TUSER_W-1:0] m_tuser,   // serial_valid[0]
  // attribute register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ATTR_W-1:0]    cfg_data
);

  localparam int PAD_W = M_TDATA_W - CURSOR_W - CHAR_W - CELL_W;

  logic [ATTR_W-1:0]     attr;
  logic [CMD_W-1:0]      cmd_q;
  logic [CHAR_W-1:0]     char_q;
  logic [CELL_IDX_W-1:0] cell_q;

  logic                  in_beat;
  logic                  out_busy;
  logic                  out_load;
  ctrl_t                 ctrl;
  dp_stat_t              dp_stat;
  logic [CURSOR_W-1:0]   cursor_index;
  logic [CELL_W-1:0]     rd_data;
  logic                  rd_ok;

  logic                  serial_valid;
  logic [CHAR_W-1:0]     serial_byte;
  logic [CELL_W-1:0]     cell_data;

  // attribute is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_valid) begin
      attr <= cfg_data;
    end
  end

  // capture the command beat; fields stay put while the program runs
  assign in_beat = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q  <= s_tdata[CMD_W-1:0];
      char_q <= s_tdata[CMD_W +: CHAR_W];
      cell_q <= s_tdata[CMD_W+CHAR_W +: CELL_IDX_W];
    end
  end

  // the output register may reload in the cycle its beat is taken
  assign out_busy = m_tvalid && !m_tready;
  assign out_load = ctrl.out_load && !out_busy;

  tccs_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_beat    (in_beat),
    .in_command (s_tdata[CMD_W-1:0]),
    .dp_stat    (dp_stat),
    .out_busy   (out_busy),
    .ctrl       (ctrl),
    .in_ready   (s_tready)
  );

  tccs_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .attr         (attr),
    .char_code    (char_q),
    .cell_index   (cell_q),
    .dp_stat      (dp_stat),
    .cursor_index (cursor_index),
    .rd_data      (rd_data),
    .rd_ok        (rd_ok)
  );

  // result fields; only put echoes, only an in-range read returns data
  assign serial_valid = (cmd_q == CMD_PUT);
  assign serial_byte  = serial_valid ? char_q : '0;
  assign cell_data    = ((cmd_q == CMD_READ) && rd_ok) ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, cell_data, serial_byte, cursor_index};
      m_tuser <= serial_valid;
    end
  end

endmodule

>>> sv/tccs_sequencer.sv
// microcode sequencer: step counter, return register, branch and dispatch logic
module tccs_sequencer
  import tccs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_beat,
  input  logic [CMD_W-1:0] in_command,
  input  dp_stat_t         dp_stat,
  input  logic             out_busy,
  output ctrl_t            ctrl,
  output logic             in_ready
);

  step_t upc;
  step_t upc_next;
  step_t ret;
  step_t ret_next;
  logic  cond_true;

  assign ctrl     = ucode(upc);
  assign in_ready = (ctrl.nx == NX_DISPATCH);

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_ROWOVER:  cond_true = dp_stat.row_over;
      C_NEWLINE:  cond_true = dp_stat.newline;
      C_LOOPMORE: cond_true = dp_stat.loop_more;
      C_OUTBUSY:  cond_true = out_busy;
      default:    cond_true = 1'b0;
    endcase
  end

  always_comb begin
    upc_next = upc;
    ret_next = ret;
    unique case (ctrl.nx)
      NX_JUMP_IF: begin
        if (cond_true) begin
          upc_next = ctrl.target;
          if (ctrl.call) ret_next = upc + 1'b1;
        end else begin
          upc_next = upc + 1'b1;
        end
      end
      NX_STAY_IF:  upc_next = cond_true ? upc : ctrl.target;
      NX_DISPATCH: upc_next = in_beat ? dispatch(in_command) : upc;
      NX_RET:      upc_next = ret;
      default:     upc_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_RSTFILL;
      ret <= ST_IDLE;
    end else begin
      upc <= upc_next;
      ret <= ret_next;
    end
  end

endmodule

>>> sv/tccs_datapath.sv
// cursor registers, sweep pointer and the cell store with its copy pipeline
module tccs_datapath
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
)(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_t                 ctrl,
  input  logic [ATTR_W-1:0]     attr,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [CELL_IDX_W-1:0] cell_index,
  output dp_stat_t              dp_stat,
  output logic [CURSOR_W-1:0]   cursor_index,
  output logic [CELL_W-1:0]     rd_data,
  output logic                  rd_ok
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int MOVE  = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int XW    = CELL_IDX_W + AW;

  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     lim_last;
  logic              loop_more;
  logic [LW-1:0]     cur_lin;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic [CELL_W-1:0] blank;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic              row_over;

  logic [CELL_W-1:0] mem [CELLS];

  assign cur_lin      = LW'(row) * LW'(COLUMNS) + LW'(col);
  assign cursor_index = CURSOR_W'(cur_lin);
  assign row_over     = (row >= RW'(ROWS));
  assign blank        = {attr, BLANK_CODE};

  always_comb begin
    unique case (ctrl.lim)
      LIM_CELLS: lim_last = AW'(CELLS - 1);
      LIM_MOVE:  lim_last = AW'(MOVE - 1);
      LIM_COLS:  lim_last = AW'(COLUMNS - 1);
      default:   lim_last = '0;
    endcase
  end
  assign loop_more = (ptr != lim_last);

  assign dp_stat = '{row_over: row_over,
                     newline: (char_code == NEWLINE_CODE),
                     loop_more: loop_more};

  // sweep pointer, back to zero when a loop ends
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctrl.lim != LIM_NONE) begin
      ptr <= loop_more ? ptr + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      unique case (ctrl.cur)
        CUR_WRAP: begin
          if (col >= CW'(COLUMNS)) begin
            col <= '0;
            row <= row + 1'b1;
          end
        end
        CUR_CLAMP: begin
          if (row_over) row <= RW'(ROWS - 1);
        end
        CUR_NEWLINE: begin
          col <= '0;
          row <= row + 1'b1;
        end
        CUR_ADV:  col <= col + 1'b1;
        CUR_HOME: begin
          col <= '0;
          row <= '0;
        end
        default: ;
      endcase
    end
  end

  // copied cell is written in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (ctrl.rd == RD_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= ptr;
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = '0;
    priority if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rd_data;
    end else begin
      unique case (ctrl.wr)
        WR_ZERO_PTR: begin
          we = 1'b1;
        end
        WR_BLANK_PTR: begin
          we    = 1'b1;
          wdata = blank;
        end
        WR_CHAR_CUR: begin
          we    = 1'b1;
          waddr = AW'(cur_lin);
          wdata = {attr, char_code};
        end
        WR_BLANK_LAST: begin
          we    = 1'b1;
          waddr = AW'(MOVE) + ptr;
          wdata = blank;
        end
        default: ;
      endcase
    end
  end

  assign re    = (ctrl.rd != RD_NONE);
  assign raddr = (ctrl.rd == RD_SHIFT) ? ptr + AW'(COLUMNS) : AW'(cell_index);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd == RD_CELL) rd_ok <= (XW'(cell_index) < XW'(CELLS));
  end

endmodule

>>> sv/tccs_checker.sv
// port-level checks for the text console, bound to the top level
module tccs_checker
  import tccs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  // store clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // one item at a time: a taken beat closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready again right after a beat");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

  // an echo result never carries cell data
  a_echo_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[CURSOR_W+CHAR_W +: CELL_W] == '0))
    else $error("cell data on a put result");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> tb/text_console_cursor_scroll_tb.sv
`timescale 1ns / 1ps
// stream testbench for the text console: directed and random commands against a shadow screen
module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam int CELL_COUNT   = COLUMNS_DEF * ROWS_DEF;
  localparam int RANDOM_ITEMS = 2000;

  // command code with no function in the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // one result beat as the shadow screen predicts it
  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_index;
    logic                serial_valid;
    logic [CHAR_W-1:0]   serial_byte;
    logic [CELL_W-1:0]   cell_data;
  } console_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;   // command[1:0], char_code[9:2], cell_index[20:10]
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;          // cursor_index[10:0], serial_byte[18:11],
                                          // cell_data[34:19]
  logic [M_TUSER_W-1:0] m_tuser;          // serial_valid[0]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [ATTR_W-1:0]    cfg_data  = '0;

  text_console_cursor_scroll uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the console state
  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  int unsigned       shadow_col;
  int unsigned       shadow_row;
  logic [ATTR_W-1:0] shadow_attr;

  console_result_t expected_results [$];

  int error_count        = 0;
  int items_sent         = 0;
  int sender_max_gap     = 5;
  int receiver_max_stall = 5;
  int next_gap           = 1;   // idle cycles before the next input beat

  // ---------------------------------------------------------------------------
  // shadow screen
  // ---------------------------------------------------------------------------

  // rows move up one, bottom row filled with blanks in the current attribute
  function automatic void scroll_shadow();
    for (int i = 0; i < CELL_COUNT - COLUMNS_DEF; i++)
      shadow_screen[i] = shadow_screen[i + COLUMNS_DEF];
    for (int i = CELL_COUNT - COLUMNS_DEF; i < CELL_COUNT; i++)
      shadow_screen[i] = {shadow_attr, BLANK_CODE};
  endfunction

  function automatic void clamp_row();
    if (shadow_row >= ROWS_DEF) begin
      shadow_row = ROWS_DEF - 1;
      scroll_shadow();
    end
  endfunction

  function automatic console_result_t console_step(input logic [CMD_W-1:0] cmd,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [CELL_IDX_W-1:0] idx);
    console_result_t r;
    r = '0;
    case (cmd)
      CMD_PUT: begin
        // a full line wraps only when the next put arrives
        if (shadow_col >= COLUMNS_DEF) begin
          shadow_col = 0;
          shadow_row++;
        end
        clamp_row();
        if (ch == NEWLINE_CODE) begin
          shadow_row++;
          shadow_col = 0;
          clamp_row();
        end else begin
          shadow_screen[shadow_row * COLUMNS_DEF + shadow_col] = {shadow_attr, ch};
          shadow_col++;
        end
        r.serial_valid = 1'b1;
        r.serial_byte  = ch;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++)
          shadow_screen[i] = {shadow_attr, BLANK_CODE};
        shadow_col = 0;
        shadow_row = 0;
      end
      CMD_READ: begin
        if (idx < CELL_COUNT)
          r.cell_data = shadow_screen[idx];
      end
      default: ;
    endcase
    r.cursor_index = CURSOR_W'(shadow_col + shadow_row * COLUMNS_DEF);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // one input beat; valid stays high into the next beat when no gap is drawn
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [CELL_IDX_W-1:0] idx);
    repeat (next_gap) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - CMD_W - CHAR_W - CELL_IDX_W){1'b0}}, idx, ch, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(console_step(cmd, ch, idx));
    items_sent++;
    next_gap = $urandom_range(0, sender_max_gap);
    if (next_gap != 0)
      s_tvalid <= 1'b0;
  endtask

  // stop the input stream and wait until every predicted result has come back
  task automatic wait_drained();
    if (next_gap == 0) begin
      s_tvalid <= 1'b0;
      next_gap = 1;
    end
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // attribute changes only while the console is idle
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_attr = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stall per beat, then compare with the oldest prediction
  initial begin : result_sink
    int              stall;
    console_result_t want;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(0, receiver_max_stall);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected, cursor_index",
                        m_tdata[10:0], 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[10:0] !== want.cursor_index)
          report_mismatch("cursor_index", m_tdata[10:0], want.cursor_index);
        if (m_tuser[0] !== want.serial_valid)
          report_mismatch("serial_valid", m_tuser[0], want.serial_valid);
        if (m_tdata[18:11] !== want.serial_byte)
          report_mismatch("serial_byte", m_tdata[18:11], want.serial_byte);
        if (m_tdata[34:19] !== want.cell_data)
          report_mismatch("cell_data", m_tdata[34:19], want.cell_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // store cleared to zero by the reset pass, out of range reads, unused command
  task automatic test_reset_contents();
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_READ, 8'hFF, CELL_IDX_W'(CELL_COUNT - 1));
    send_item(CMD_READ, 8'h00, CELL_IDX_W'(CELL_COUNT));
    send_item(CMD_READ, 8'h00, 11'h7FF);
    send_item(CMD_UNUSED, 8'hFF, 11'h7FF);
  endtask

  // character extremes with the reset attribute, newline mid line, read back
  task automatic test_put_extremes();
    send_item(CMD_PUT, 8'h00, 11'd0);
    send_item(CMD_PUT, 8'hFF, 11'h7FF);
    send_item(CMD_PUT, NEWLINE_CODE, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd1);
    send_item(CMD_READ, 8'h00, 11'd2);
  endtask

  // attribute extremes on written characters and on clear blanks
  task automatic test_attribute_settings();
    write_attribute(8'h00);
    send_item(CMD_PUT, 8'h78, 11'd0);
    send_item(CMD_READ, 8'h00, CELL_IDX_W'(COLUMNS_DEF));
    write_attribute(8'hFF);
    send_item(CMD_CLEAR, 8'hFF, 11'h7FF);
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_READ, 8'h00, CELL_IDX_W'(CELL_COUNT - 1));
    send_item(CMD_PUT, NEWLINE_CODE, 11'd0);
    send_item(CMD_PUT, 8'h41, 11'd0);
  endtask

  // lines of text with wraps, newlines and scrolls, mixed with reads and noise
  task automatic test_random_text();
    int                    goal;
    int                    line_len;
    int                    pick;
    logic [CHAR_W-1:0]     ch;
    logic [CELL_IDX_W-1:0] idx;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      // pacing for this line, with some stretches fully back to back
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        sender_max_gap     = 0;
        receiver_max_stall = 0;
      end else if (pick < 25) begin
        sender_max_gap     = 0;
        receiver_max_stall = 5;
      end else if (pick < 35) begin
        sender_max_gap     = 5;
        receiver_max_stall = 0;
      end else begin
        sender_max_gap     = 5;
        receiver_max_stall = 5;
      end

      // occasional clear, attribute change or noise between lines
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                  CELL_IDX_W'($urandom_range(0, 2047)));
      end else if (pick < 7) begin
        case ($urandom_range(0, 2))
          0:       write_attribute(8'h00);
          1:       write_attribute(8'hFF);
          default: write_attribute(ATTR_W'($urandom_range(0, 255)));
        endcase
      end else if (pick < 10) begin
        send_item(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)),
                  CELL_IDX_W'($urandom_range(0, 2047)));
      end else if (pick < 13) begin
        send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                  CELL_IDX_W'($urandom_range(CELL_COUNT, 2047)));
      end

      // line length: short, partial, exactly full (wrap pending), or longer than a row
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // run of bare newlines keeps the cursor on the bottom row
        repeat ($urandom_range(1, 30))
          send_item(CMD_PUT, NEWLINE_CODE, CELL_IDX_W'($urandom_range(0, 2047)));
        continue;
      end else if (pick < 50) begin
        line_len = $urandom_range(0, 10);
      end else if (pick < 65) begin
        line_len = $urandom_range(11, COLUMNS_DEF - 1);
      end else if (pick < 85) begin
        line_len = COLUMNS_DEF;
      end else begin
        line_len = $urandom_range(COLUMNS_DEF + 1, 2 * COLUMNS_DEF + 10);
      end

      for (int k = 0; k < line_len; k++) begin
        if ($urandom_range(0, 5) == 0)
          send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                    CELL_IDX_W'($urandom_range(0, CELL_COUNT - 1)));
        do ch = CHAR_W'($urandom_range(0, 255)); while (ch == NEWLINE_CODE);
        send_item(CMD_PUT, ch, CELL_IDX_W'($urandom_range(0, 2047)));
        // read back the cell just written
        if ($urandom_range(0, 4) == 0) begin
          idx = CELL_IDX_W'(shadow_row * COLUMNS_DEF + shadow_col - 1);
          send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), idx);
        end
      end
      if ($urandom_range(0, 9) != 0)
        send_item(CMD_PUT, NEWLINE_CODE, CELL_IDX_W'($urandom_range(0, 2047)));
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < CELL_COUNT; i++)
      shadow_screen[i] = '0;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = ATTR_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_contents();
    test_put_extremes();
    test_attribute_settings();
    test_random_text();

    wait_drained();
    // a stray result beat would show up in this wait
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("text_console_cursor_scroll_tb: PASS");
    else
      $display("text_console_cursor_scroll_tb: FAIL");
    $finish;
  end

  // many times the expected run, scrolls and clears included
  initial begin : watchdog
    #(20_000_000);
    $display("text_console_cursor_scroll_tb: FAIL");
    $finish;
  end

endmodule

>>> text_console_cursor_scroll.f
sv/tccs_pkg.sv
sv/tccs_sequencer.sv
sv/tccs_datapath.sv
sv/text_console_cursor_scroll.sv
sv/tccs_checker.sv
tb/text_console_cursor_scroll_tb.sv
